>>> sv/rope_pkg.sv
package rope_pkg;

    localparam int MAX_HEAD   = 256;
    localparam int HALF_DEPTH = MAX_HEAD / 2;
    localparam int ADDR_W     = $clog2(HALF_DEPTH);
    localparam int IDX_W      = 8;
    localparam int CFG_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int VAL_W      = 16;
    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_HEAD_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATED_SIZE = 2'd1;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PASS,
        KIND_ROT
    } rope_kind_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] cos_v;
        logic signed [VAL_W-1:0] sin_v;
    } rope_entry_t;

    typedef struct packed {
        rope_kind_t              kind;
        logic signed [VAL_W-1:0] x;
        logic [IDX_W-1:0]        idx_i;
        logic [IDX_W-1:0]        idx_p;
        logic                    done;
        logic                    err;
    } rope_ctl_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        index;
        logic                    last;
        logic                    done;
        logic                    err;
    } rope_res_t;

endpackage

>>> sv/rotary_position_embedding.sv
// Channel   Direction  Signals                       Contents
// s_*       in         tvalid tready tdata[47:0]     elem_value, cos_val, sin_val
// m_*       out        tvalid tready tdata[23:0]     out_value, out_index
//                      tlast tuser[1:0]              run_last; head_done, config_error
// cfg_*     in         valid ready index[1:0] data   head_size, rotated_size
//
// One element is accepted per cycle while the result queue has room for two results.
// A second-half element of the rotated span yields two results, so a run of them fills the queue faster than it drains.
// A result is offered once its element has passed the store read, the multiply registers,
// then rounding into the queue.
// Reset clears the counter, the pipeline and the queue; the store holds no reset.
// The input is held off while fewer than two of the eight queue places are free,
// counting results still in the pipeline.
module rotary_position_embedding (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [47:0]                     s_tdata,  // elem_value, cos_val, sin_val
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,  // out_value, out_index
    output logic                            m_tlast,
    output logic [1:0]                      m_tuser,  // head_done, config_error
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rope_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rope_pkg::CFG_W-1:0]      cfg_data
);
    import rope_pkg::*;

    logic [CFG_W-1:0]       head_size_reg;
    logic [CFG_W-1:0]       rotated_size_reg;
    logic [IDX_W-1:0]       cnt_reg;
    logic [IDX_W-1:0]       cnt_next;
    logic [OUTQ_CNT_W-1:0]  used_reg;
    logic [OUTQ_CNT_W-1:0]  used_next;
    rope_ctl_t              ctl_reg;
    rope_ctl_t              ctl_next;

    logic                   accept;
    logic                   pop;
    logic [CFG_W-1:0]       len;
    logic [CFG_W-1:0]       pos;
    logic [IDX_W-1:0]       half;
    logic                   err;
    logic                   done;
    logic                   pass;
    logic                   store;
    logic [1:0]             nres;
    rope_entry_t            wentry;
    rope_entry_t            rentry;
    logic [1:0]             push_cnt;
    rope_res_t              res0;
    rope_res_t              res1;
    rope_res_t              head;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign pop       = m_tvalid && m_tready;
    assign s_tready  = (used_reg <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));

    always_comb
    begin
        if (head_size_reg < CFG_W'(2))
        begin
            len = CFG_W'(2);
        end
        else if (head_size_reg > CFG_W'(MAX_HEAD))
        begin
            len = CFG_W'(MAX_HEAD);
        end
        else
        begin
            len = head_size_reg;
        end
    end

    assign pos   = {1'b0, cnt_reg};
    assign half  = rotated_size_reg[CFG_W-1:1];
    assign err   = rotated_size_reg[0] || (rotated_size_reg > len);
    assign done  = (pos + CFG_W'(1)) >= len;
    assign pass  = err || (pos >= rotated_size_reg);
    assign store = !pass && (cnt_reg < half);
    assign cnt_next = done ? '0 : cnt_reg + IDX_W'(1);

    always_comb
    begin
        ctl_next.x     = s_tdata[15:0];
        ctl_next.idx_i = cnt_reg - half;
        ctl_next.idx_p = cnt_reg;
        ctl_next.done  = done;
        ctl_next.err   = err;
        if (!accept)
        begin
            ctl_next.kind = KIND_NONE;
            nres          = 2'd0;
        end
        else if (pass || (store && done))
        begin
            ctl_next.kind = KIND_PASS;
            nres          = 2'd1;
        end
        else if (store)
        begin
            ctl_next.kind = KIND_NONE;
            nres          = 2'd0;
        end
        else
        begin
            ctl_next.kind = KIND_ROT;
            nres          = 2'd2;
        end
    end

    assign used_next = used_reg + OUTQ_CNT_W'(nres) - OUTQ_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_size_reg    <= CFG_W'(128);
            rotated_size_reg <= CFG_W'(128);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_HEAD_SIZE:    head_size_reg    <= cfg_data;
                REG_ROTATED_SIZE: rotated_size_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            used_reg <= '0;
            ctl_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                cnt_reg <= cnt_next;
            end
            used_reg <= used_next;
            ctl_reg  <= ctl_next;
        end
    end

    assign wentry = '{value: s_tdata[15:0], cos_v: s_tdata[31:16], sin_v: s_tdata[47:32]};

    rope_store u_store (
        .clk   (clk),
        .we    (accept && store),
        .waddr (cnt_reg[ADDR_W-1:0]),
        .wdata (wentry),
        .re    (ctl_next.kind == KIND_ROT),
        .raddr (ctl_next.idx_i[ADDR_W-1:0]),
        .rdata (rentry)
    );

    rope_rotate u_rotate (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_reg),
        .pair     (rentry),
        .push_cnt (push_cnt),
        .res0     (res0),
        .res1     (res1)
    );

    rope_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (push_cnt),
        .din0       (res0),
        .din1       (res1),
        .dout_valid (m_tvalid),
        .dout_ready (m_tready),
        .dout       (head)
    );

    assign m_tdata = {head.index, head.value};
    assign m_tlast = head.last;
    assign m_tuser = {head.err, head.done};

    // The credit count must never promise more results than the queue can hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= OUTQ_CNT_W'(OUTQ_DEPTH))
        else $error("result credit count exceeds queue depth");

    // A store write and a store read never fall in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && store && (ctl_next.kind == KIND_ROT)))
        else $error("store written and read in the same cycle");

    // A rotated element pushes both of its results after passing ctl_reg and the rotate stage's kind_reg.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_next.kind == KIND_ROT) |-> ##2 (push_cnt == 2'd2))
        else $error("rotated element did not push two results");

    // The final element of a head returns the position counter to zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && done) |=> (cnt_reg == '0))
        else $error("position counter not cleared at end of head");

endmodule

>>> sv/rope_store.sv
module rope_store (
    input  logic                         clk,
    input  logic                         we,
    input  logic [rope_pkg::ADDR_W-1:0]  waddr,
    input  rope_pkg::rope_entry_t        wdata,
    input  logic                         re,
    input  logic [rope_pkg::ADDR_W-1:0]  raddr,
    output rope_pkg::rope_entry_t        rdata
);
    import rope_pkg::*;

    rope_entry_t mem [HALF_DEPTH];
    rope_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/rope_rotate.sv
module rope_rotate (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rope_pkg::rope_ctl_t    ctl,
    input  rope_pkg::rope_entry_t  pair,
    output logic [1:0]             push_cnt,
    output rope_pkg::rope_res_t    res0,
    output rope_pkg::rope_res_t    res1
);
    import rope_pkg::*;

    function automatic logic signed [VAL_W-1:0] round_sat(input logic signed [32:0] v);
        logic signed [33:0] t;
        logic signed [19:0] q;
        t = {v[32], v} + 34'sd8192;
        q = t[33:14];
        if (q > 20'sd32767)
        begin
            return 16'sh7fff;
        end
        else if (q < -20'sd32768)
        begin
            return 16'sh8000;
        end
        return q[15:0];
    endfunction

    rope_kind_t         kind_reg;
    rope_ctl_t          ctl_reg;
    logic signed [31:0] p_x0c_reg;
    logic signed [31:0] p_x1s_reg;
    logic signed [31:0] p_x1c_reg;
    logic signed [31:0] p_x0s_reg;
    logic signed [32:0] sum_a;
    logic signed [32:0] sum_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_NONE;
        end
        else
        begin
            kind_reg <= ctl.kind;
        end
    end

    always_ff @(posedge clk)
    begin
        ctl_reg   <= ctl;
        p_x0c_reg <= pair.value * pair.cos_v;
        p_x1s_reg <= ctl.x * pair.sin_v;
        p_x1c_reg <= ctl.x * pair.cos_v;
        p_x0s_reg <= pair.value * pair.sin_v;
    end

    assign sum_a = 33'(p_x0c_reg) - 33'(p_x1s_reg);
    assign sum_b = 33'(p_x1c_reg) + 33'(p_x0s_reg);

    always_comb
    begin
        res0     = '{value: ctl_reg.x, index: ctl_reg.idx_p, last: 1'b1,
                     done: ctl_reg.done, err: ctl_reg.err};
        res1     = res0;
        push_cnt = 2'd0;
        unique case (kind_reg)
            KIND_PASS:
            begin
                push_cnt = 2'd1;
            end
            KIND_ROT:
            begin
                push_cnt = 2'd2;
                res0 = '{value: round_sat(sum_a), index: ctl_reg.idx_i, last: 1'b0,
                         done: 1'b0, err: 1'b0};
                res1 = '{value: round_sat(sum_b), index: ctl_reg.idx_p, last: 1'b1,
                         done: ctl_reg.done, err: 1'b0};
            end
            default:
            begin
                push_cnt = 2'd0;
            end
        endcase
    end

endmodule

>>> sv/rope_outq.sv
module rope_outq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           push_cnt,
    input  rope_pkg::rope_res_t  din0,
    input  rope_pkg::rope_res_t  din1,
    output logic                 dout_valid,
    input  logic                 dout_ready,
    output rope_pkg::rope_res_t  dout
);
    import rope_pkg::*;

    rope_res_t               entries_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]   wr_ptr_reg;
    logic [OUTQ_PTR_W-1:0]   wr_ptr_next;
    logic [OUTQ_PTR_W-1:0]   rd_ptr_reg;
    logic [OUTQ_PTR_W-1:0]   rd_ptr_next;
    logic [OUTQ_CNT_W-1:0]   count_reg;
    logic [OUTQ_CNT_W-1:0]   count_next;
    logic                    pop;

    assign dout_valid  = (count_reg != '0);
    assign dout        = entries_reg[rd_ptr_reg];
    assign pop         = dout_valid && dout_ready;
    assign wr_ptr_next = wr_ptr_reg + OUTQ_PTR_W'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + OUTQ_PTR_W'(pop);
    assign count_next  = count_reg + OUTQ_CNT_W'(push_cnt) - OUTQ_CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            entries_reg[wr_ptr_reg] <= din0;
        end
        if (push_cnt == 2'd2)
        begin
            entries_reg[wr_ptr_reg + OUTQ_PTR_W'(1)] <= din1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
